>>> sv/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  localparam int TIMER_WIDTH_DEF    = 24;
  localparam int DISTANCE_WIDTH_DEF = 17;

  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int INTERVAL_W  = 24;
  localparam int DIST_CFG_W  = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INTERVAL  = 3'd0,
    REG_TIMEOUT   = 3'd1,
    REG_MIN_DIST  = 3'd2,
    REG_MAX_DIST  = 3'd3,
    REG_THRESHOLD = 3'd4
  } reg_index_t;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = 24'd500000;
  localparam logic [INTERVAL_W-1:0] TIMEOUT_RST   = 24'd30000;
  localparam logic [DIST_CFG_W-1:0] MIN_DIST_RST  = 17'd512;
  localparam logic [DIST_CFG_W-1:0] MAX_DIST_RST  = 17'd102400;
  localparam logic [DIST_CFG_W-1:0] THRESHOLD_RST = 17'd2560;

  // multiplier coefficients: speed of sound in Q0.16 cm per us round trip, EMA weights
  localparam int               COEF_W     = 11;
  localparam logic [COEF_W-1:0] SOUND_Q8  = 11'd1124;
  localparam logic [COEF_W-1:0] ALPHA_NEW = 11'd154;
  localparam logic [COEF_W-1:0] ALPHA_OLD = 11'd102;
  localparam int               ROUND_HALF = 128;

  localparam int LOW_TICKS  = 2;
  localparam int HIGH_TICKS = 10;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic [INTERVAL_W-1:0] timeout;
    logic [DIST_CFG_W-1:0] min_dist;
    logic [DIST_CFG_W-1:0] max_dist;
    logic [DIST_CFG_W-1:0] threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_WAIT_FALL = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE  = 3'd0,
    SQ_STEP  = 3'd1,
    SQ_RAW   = 3'd2,
    SQ_CHECK = 3'd3,
    SQ_NEW   = 3'd4,
    SQ_OLD   = 3'd5,
    SQ_FIN   = 3'd6,
    SQ_PUSH  = 3'd7
  } seq_t;

endpackage

`default_nettype wire

>>> sv/uer_if.sv
// ----------------------------------------------------------------------------
// uer_if
// Valid/ready channels: echo samples in, tick results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

interface uer_out_if #(
  parameter int DISTANCE_WIDTH = uer_pkg::DISTANCE_WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic                      trigger_level;
  logic                      reading_ready;
  logic [DISTANCE_WIDTH-1:0] distance_q8;
  logic                      near_threshold;
  logic                      reading_rejected;
  logic                      measuring;

  modport source (output valid, output trigger_level, output reading_ready,
                  output distance_q8, output near_threshold,
                  output reading_rejected, output measuring, input ready);
  modport sink   (input valid, input trigger_level, input reading_ready,
                  input distance_q8, input near_threshold,
                  input reading_rejected, input measuring, output ready);
endinterface

`default_nettype wire

>>> sv/uer_mac.sv
// ----------------------------------------------------------------------------
// uer_mac
// Shared multiply-add unit, y = a * b + c, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_mac #(
  parameter int A_W = 24,
  parameter int C_W = 36
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [A_W-1:0]            a,
  input  wire logic [uer_pkg::COEF_W-1:0] b,
  input  wire logic [C_W-1:0]            c,
  output      logic [C_W-1:0]            y
);
  import uer_pkg::*;

  logic [A_W+COEF_W-1:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      y <= C_W'(prod) + c;
    end
  end

endmodule

`default_nettype wire

>>> sv/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Tick sequencer: trigger/echo phase machine, distance and EMA steps on the
// shared multiply-add unit, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_ctrl #(
  parameter int TIMER_WIDTH    = uer_pkg::TIMER_WIDTH_DEF,
  parameter int DISTANCE_WIDTH = uer_pkg::DISTANCE_WIDTH_DEF,
  parameter int MW             = 24,
  parameter int PW             = 36
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire uer_pkg::cfg_t              cfg,
  uer_in_if.sink                          echo_in,
  uer_out_if.source                       result_out,
  output      logic                       mac_en,
  output      logic [MW-1:0]              mac_a,
  output      logic [uer_pkg::COEF_W-1:0] mac_b,
  output      logic [PW-1:0]              mac_c,
  input  wire logic [PW-1:0]              mac_y
);
  import uer_pkg::*;

  localparam int TW  = TIMER_WIDTH;
  localparam int DW  = DISTANCE_WIDTH;
  localparam int CW  = (TW > INTERVAL_W) ? TW : INTERVAL_W;
  localparam int RW  = PW - 8;
  localparam int DCW = (DW > DIST_CFG_W) ? DW : DIST_CFG_W;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};
  localparam logic [DW-1:0] DMAX = {DW{1'b1}};

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
    return (v == TMAX) ? v : v + 1'b1;
  endfunction

  function automatic logic expired(input logic [TW-1:0] t, input logic [INTERVAL_W-1:0] lim);
    return (t == TMAX) || (CW'(t) > CW'(lim));
  endfunction

  function automatic logic [DW-1:0] clamp_d(input logic [RW-1:0] v);
    return (v > RW'(DMAX)) ? DMAX : v[DW-1:0];
  endfunction

  seq_t   sq, sq_next;
  phase_t phase, phase_next;

  logic [TW-1:0] timer, timer_next, timer_sat;
  logic [TW-1:0] dur, dur_next, dur_sat;
  logic [TW-1:0] slr, slr_next, slr_inc;
  logic          trig_tick, fall_tick;

  logic          echo;
  logic          has_seed, use_seed;
  logic [DW-1:0] smooth, fresh;
  logic [RW-1:0] raw;
  logic          raw_bad;
  logic [DW-1:0] ema;

  logic r_trig, r_ready, r_near, r_rej, r_meas;
  logic out_valid, o_trig, o_ready, o_near, o_rej, o_meas;
  logic [DW-1:0] o_dist;
  logic accept, slot_free, load;

  assign accept    = echo_in.valid && echo_in.ready;
  assign slot_free = !out_valid || result_out.ready;

  // one tick of the trigger/echo phase machine
  always_comb begin
    slr_inc    = sat_inc(slr);
    timer_sat  = sat_inc(timer);
    dur_sat    = sat_inc(dur);
    phase_next = phase;
    timer_next = timer;
    dur_next   = dur;
    slr_next   = slr_inc;
    trig_tick  = 1'b0;
    fall_tick  = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (slr_inc == TMAX || CW'(slr_inc) >= CW'(cfg.interval)) begin
          phase_next = PH_TRIG_LOW;
          timer_next = '0;
        end
      end
      PH_TRIG_LOW: begin
        timer_next = timer_sat;
        if (timer_sat >= TW'(LOW_TICKS)) begin
          phase_next = PH_TRIG_HIGH;
          timer_next = '0;
        end
      end
      PH_TRIG_HIGH: begin
        trig_tick  = 1'b1;
        timer_next = timer_sat;
        if (timer_sat >= TW'(HIGH_TICKS)) begin
          phase_next = PH_WAIT_RISE;
          timer_next = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase_next = PH_WAIT_FALL;
          dur_next   = '0;
        end else begin
          timer_next = timer_sat;
          if (expired(timer_sat, cfg.timeout)) begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_WAIT_FALL: begin
        dur_next = dur_sat;
        if (!echo) begin
          fall_tick  = 1'b1;
          slr_next   = '0;
          phase_next = PH_IDLE;
        end else if (expired(dur_sat, cfg.timeout)) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  assign raw     = mac_y[PW-1:8];
  assign raw_bad = (raw < RW'(cfg.min_dist)) || (raw > RW'(cfg.max_dist));
  assign ema     = use_seed ? fresh : clamp_d(raw);

  // sequencer next state
  always_comb begin
    sq_next = sq;
    unique case (sq)
      SQ_IDLE:  if (accept) sq_next = SQ_STEP;
      SQ_STEP:  sq_next = fall_tick ? SQ_RAW : SQ_PUSH;
      SQ_RAW:   sq_next = SQ_CHECK;
      SQ_CHECK: begin
        if (raw_bad) begin
          sq_next = SQ_PUSH;
        end else if (!has_seed) begin
          sq_next = SQ_FIN;
        end else begin
          sq_next = SQ_NEW;
        end
      end
      SQ_NEW:   sq_next = SQ_OLD;
      SQ_OLD:   sq_next = SQ_FIN;
      SQ_FIN:   sq_next = SQ_PUSH;
      SQ_PUSH:  if (slot_free) sq_next = SQ_IDLE;
      default:  sq_next = SQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    echo_in.ready = 1'b0;
    load          = 1'b0;
    mac_en        = 1'b0;
    mac_a         = '0;
    mac_b         = '0;
    mac_c         = '0;
    unique case (sq)
      SQ_IDLE: echo_in.ready = 1'b1;
      SQ_RAW: begin
        mac_en = 1'b1;
        mac_a  = MW'(dur);
        mac_b  = SOUND_Q8;
      end
      SQ_NEW: begin
        mac_en = 1'b1;
        mac_a  = MW'(fresh);
        mac_b  = ALPHA_NEW;
        mac_c  = PW'(ROUND_HALF);
      end
      SQ_OLD: begin
        mac_en = 1'b1;
        mac_a  = MW'(smooth);
        mac_b  = ALPHA_OLD;
        mac_c  = mac_y;
      end
      SQ_PUSH: load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq        <= SQ_IDLE;
      phase     <= PH_IDLE;
      timer     <= '0;
      dur       <= '0;
      slr       <= TMAX;
      smooth    <= '0;
      has_seed  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sq <= sq_next;
      if (sq == SQ_STEP) begin
        phase <= phase_next;
        timer <= timer_next;
        dur   <= dur_next;
        slr   <= slr_next;
      end
      if (sq == SQ_CHECK && raw_bad) begin
        smooth   <= '0;
        has_seed <= 1'b0;
      end
      if (sq == SQ_FIN) begin
        smooth   <= ema;
        has_seed <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      echo <= echo_in.echo_level;
    end
    if (sq == SQ_STEP) begin
      r_trig  <= trig_tick;
      r_meas  <= (phase != PH_IDLE) || (phase_next != PH_IDLE);
      r_ready <= 1'b0;
      r_near  <= 1'b0;
      r_rej   <= 1'b0;
    end
    if (sq == SQ_CHECK) begin
      r_rej    <= raw_bad;
      fresh    <= clamp_d(raw);
      use_seed <= !has_seed;
    end
    if (sq == SQ_FIN) begin
      r_ready <= 1'b1;
      r_near  <= DCW'(ema) <= DCW'(cfg.threshold);
    end
    if (load) begin
      o_trig  <= r_trig;
      o_ready <= r_ready;
      o_dist  <= smooth;
      o_near  <= r_near;
      o_rej   <= r_rej;
      o_meas  <= r_meas;
    end
  end

  assign result_out.valid            = out_valid;
  assign result_out.trigger_level    = o_trig;
  assign result_out.reading_ready    = o_ready;
  assign result_out.distance_q8      = o_dist;
  assign result_out.near_threshold   = o_near;
  assign result_out.reading_rejected = o_rej;
  assign result_out.measuring        = o_meas;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !echo_in.ready)
    else $error("input taken while a tick is in progress");

  a_ready_xor_rej: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(o_ready && o_rej))
    else $error("reading both accepted and rejected");

  a_near_needs_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_near) |-> o_ready)
    else $error("near flag without a reading");

  a_trig_measuring: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_trig) |-> o_meas)
    else $error("trigger high outside a measurement");

endmodule

`default_nettype wire

>>> sv/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Ultrasonic time-of-flight ranger, one echo sample per microsecond tick in,
// one result per tick out: trigger pulse, echo timing, range check, EMA.
//
//   channel     dir  handshake        payload
//   echo_in     in   valid/ready      echo_level
//   result_out  out  valid/ready      trigger_level, reading_ready,
//                                     distance_q8, near_threshold,
//                                     reading_rejected, measuring
//   cfg         in   cfg_we           cfg_index, cfg_data
//
// A tick passes SQ_STEP and SQ_PUSH to the output register; an echo fall adds
// SQ_RAW (distance multiply) and SQ_CHECK, then SQ_PUSH when rejected, SQ_FIN
// first when it seeds the average, SQ_NEW, SQ_OLD, SQ_FIN when it updates it,
// the two EMA multiply-adds taking turns on the one shared multiply-add unit.
// Only one tick is in the block at a time; echo_in.ready is high in idle.
// A finished result waits in the output register; a new tick can be taken
// meanwhile, and only its own transfer out waits on result_out.ready.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_unit #(
  parameter int TIMER_WIDTH    = uer_pkg::TIMER_WIDTH_DEF,
  parameter int DISTANCE_WIDTH = uer_pkg::DISTANCE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
  uer_in_if.sink                              echo_in,
  uer_out_if.source                           result_out
);
  import uer_pkg::*;

  localparam int MW = (TIMER_WIDTH > DISTANCE_WIDTH) ? TIMER_WIDTH : DISTANCE_WIDTH;
  localparam int PW = MW + COEF_W + 1;

  cfg_t cfg;

  logic              mac_en;
  logic [MW-1:0]     mac_a;
  logic [COEF_W-1:0] mac_b;
  logic [PW-1:0]     mac_c;
  logic [PW-1:0]     mac_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval  <= INTERVAL_RST;
      cfg.timeout   <= TIMEOUT_RST;
      cfg.min_dist  <= MIN_DIST_RST;
      cfg.max_dist  <= MAX_DIST_RST;
      cfg.threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERVAL:  cfg.interval  <= cfg_data[INTERVAL_W-1:0];
        REG_TIMEOUT:   cfg.timeout   <= cfg_data[INTERVAL_W-1:0];
        REG_MIN_DIST:  cfg.min_dist  <= cfg_data[DIST_CFG_W-1:0];
        REG_MAX_DIST:  cfg.max_dist  <= cfg_data[DIST_CFG_W-1:0];
        REG_THRESHOLD: cfg.threshold <= cfg_data[DIST_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  uer_ctrl #(
    .TIMER_WIDTH    (TIMER_WIDTH),
    .DISTANCE_WIDTH (DISTANCE_WIDTH),
    .MW             (MW),
    .PW             (PW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .echo_in    (echo_in),
    .result_out (result_out),
    .mac_en     (mac_en),
    .mac_a      (mac_a),
    .mac_b      (mac_b),
    .mac_c      (mac_c),
    .mac_y      (mac_y)
  );

  uer_mac #(
    .A_W (MW),
    .C_W (PW)
  ) u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .y   (mac_y)
  );

endmodule

`default_nettype wire
